@@ hw/rtl/pwfp_pkg.sv @@
// Shared types and constants for the pulse width measurement block.
`timescale 1ns / 1ps
`default_nettype none
package pwfp_pkg;
	localparam int SW   = 16;  // sample width
	localparam int AMPW = 17;  // baseline-subtracted amplitude width
	localparam int LW   = 42;  // level width, Q16 samples
	localparam int DW   = 48;  // dividend width
	localparam int DVW  = 18;  // divisor width
	localparam int DCW  = 6;   // divider step counter width

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

	localparam logic [15:0] FRACTION_RESET  = 16'd32768;
	localparam logic [15:0] THRESHOLD_RESET = 16'd1280;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_bin;
		logic signed [15:0] bg_mean;
		logic [15:0]        baseline_sigma;
	} in_item_t;

	typedef struct packed {
		logic [15:0] width_turns;
		logic [14:0] width_error;
		logic        below_noise;
	} out_item_t;
endpackage
`default_nettype wire

@@ hw/rtl/pulse_width_at_fraction_of_peak.sv @@
// Pulse width at a fraction of the profile extreme (peak or trough), with memory-held profile.
//
// Usage: profile bins arrive on the item channel (item_valid/item_ready),
// one bin per cycle while loading; the item with last_bin set also carries
// the baseline mean and sigma. For each such item one result leaves on the
// result channel (result_valid/result_ready). Bins past NBIN_MAX are dropped.
// After the last bin come two setup steps (S_PREP, S_MUL), then three
// tries, each with a level step and noise check (S_LEV, S_CHK), the left
// and right edge walks (a profile memory read in S_WRD, a compare in
// S_WCK), edge reads (S_E1 to S_E3), two divisions of the edge offsets and
// one of the width in the shared bit-serial divider, and wrap steps (S_WRAP,
// S_DIST); S_ERR and S_FIN then post the result.
// A try under the noise threshold ends the profile early.
// Loading runs at one bin per cycle.
// The result sits in an output register: the next profile loads while it
// waits; a finished computation holds until that register is free.
// Reset clears counters, extremes, last error and configuration (fraction
// 0.5, threshold 5.0 sigma); the profile memory is not cleared.
// Configuration should be written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module pulse_width_at_fraction_of_peak
	import pwfp_pkg::*;
#(
	parameter int NBIN_MAX = 1024
)(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire in_item_t             item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output out_item_t                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);
	localparam int AW = $clog2(NBIN_MAX);
	localparam int CW = $clog2(NBIN_MAX + 1);

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_MUL  = 4'd2;
	localparam logic [3:0] S_LEV  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_WRD  = 4'd5;
	localparam logic [3:0] S_WCK  = 4'd6;
	localparam logic [3:0] S_E1   = 4'd7;
	localparam logic [3:0] S_E2   = 4'd8;
	localparam logic [3:0] S_E3   = 4'd9;
	localparam logic [3:0] S_DVO  = 4'd10;
	localparam logic [3:0] S_WRAP = 4'd11;
	localparam logic [3:0] S_DIST = 4'd12;
	localparam logic [3:0] S_DVW  = 4'd13;
	localparam logic [3:0] S_ERR  = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	logic [3:0] state_q;
	logic [15:0] frac_q, nthr_q;

	logic signed [SW-1:0] mem [NBIN_MAX];
	logic [AW-1:0] rd_addr;
	logic signed [SW-1:0] rd_data_q;

	logic [CW-1:0] bin_count_q;
	logic signed [SW-1:0] peak_q, trough_q;
	logic [AW-1:0] peak_idx_q, trough_idx_q;
	logic signed [SW-1:0] mean_q;
	logic [15:0] sigma_q;

	logic [CW-1:0] n_q;
	logic [AW-1:0] pk_q;
	logic signed [AMPW-1:0] ext_q;
	logic signed [33:0] base_q;
	logic [39:0] thr_q;
	logic [1:0] try_q;
	logic signed [LW-1:0] lev_q;
	logic [LW-1:0] alev_q;
	logic dir_q;
	logic [AW-1:0] idx_q, x2_idx_q;
	logic [CW-1:0] k_q, kl_q;
	logic signed [AMPW-1:0] y1_q;
	logic signed [DW-1:0] offl_q, dist_q;
	logic [15:0] w_q [3];
	logic [15:0] last_err_q;
	out_item_t pend_q, result_q;
	logic result_valid_q;

	logic [DW-1:0] dv_quo_q;
	logic [DVW:0] dv_rem_q;
	logic [DVW-1:0] dv_den_q;
	logic dv_neg_q;
	logic [DCW-1:0] dv_cnt_q;

	logic accept, wr_en;
	logic signed [AMPW-1:0] amp_c, dmax_c, dmin_c, dmag_c;
	logic [AMPW-1:0] abs_amp, abs_dmax, abs_dmin;
	logic [LW-1:0] amp_big, abs_lev;
	logic [CW-1:0] n_m1;
	logic [AW-1:0] idx_inc, idx_dec;
	logic signed [LW-1:0] sig16, lev_c;
	logic walk_pass, walk_stop;
	logic signed [DW-1:0] num_c, num_mag, q_signed, ksum16;
	logic signed [AMPW:0] den_c;
	logic [DVW-1:0] den_mag;
	logic [DVW:0] rem_sh, rem_sub;
	logic signed [CW+1:0] ksum;
	logic signed [16:0] wdiff;
	logic [16:0] wdiff_abs;

	assign item_ready   = (state_q == S_LOAD);
	assign accept       = item_valid && item_ready;
	assign wr_en        = accept && (bin_count_q < CW'(NBIN_MAX));
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[bin_count_q[AW-1:0]] <= item.sample;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = (state_q == S_E2) ? x2_idx_q : idx_q;
		amp_c   = AMPW'(rd_data_q) - AMPW'(mean_q);
		abs_amp = amp_c[AMPW-1] ? AMPW'(-amp_c) : AMPW'(amp_c);
		amp_big = {{(LW-AMPW-16){1'b0}}, abs_amp, 16'b0};
		dmax_c  = AMPW'(peak_q) - AMPW'(mean_q);
		dmin_c  = AMPW'(trough_q) - AMPW'(mean_q);
		abs_dmax = dmax_c[AMPW-1] ? AMPW'(-dmax_c) : AMPW'(dmax_c);
		abs_dmin = dmin_c[AMPW-1] ? AMPW'(-dmin_c) : AMPW'(dmin_c);
		dmag_c  = (abs_dmax > abs_dmin) ? dmax_c : dmin_c;
		n_m1    = n_q - CW'(1);
		idx_inc = (idx_q == n_m1[AW-1:0]) ? '0 : idx_q + AW'(1);
		idx_dec = (idx_q == '0) ? n_m1[AW-1:0] : idx_q - AW'(1);
		sig16   = $signed({{(LW-32){1'b0}}, sigma_q, 16'b0});
		case (try_q)
			2'd0:    lev_c = $signed({{(LW-34){base_q[33]}}, base_q}) - sig16;
			2'd1:    lev_c = $signed({{(LW-34){base_q[33]}}, base_q});
			default: lev_c = $signed({{(LW-34){base_q[33]}}, base_q}) + sig16;
		endcase
		abs_lev   = lev_q[LW-1] ? LW'(-lev_q) : LW'(lev_q);
		walk_pass = amp_big > alev_q;
		walk_stop = ((state_q == S_WRD) && (k_q == n_q)) ||
			((state_q == S_WCK) && !walk_pass);
		// divider operands: edge offset or width
		if (state_q == S_E3) begin
			num_c = $signed({{(DW-LW){lev_q[LW-1]}}, lev_q}) -
				$signed({{(DW-AMPW-16){y1_q[AMPW-1]}}, y1_q, 16'b0});
			den_c = (AMPW+1)'(amp_c) - (AMPW+1)'(y1_q);
		end else begin
			num_c = dist_q;
			den_c = $signed({{(AMPW+1-CW){1'b0}}, n_q});
		end
		num_mag = num_c[DW-1] ? -num_c : num_c;
		den_mag = den_c[AMPW] ? DVW'(-den_c) : DVW'(den_c);
		rem_sh  = {dv_rem_q[DVW-1:0], dv_quo_q[DW-1]};
		rem_sub = rem_sh - {1'b0, dv_den_q};
		q_signed = dv_neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q);
		ksum    = $signed({2'b0, kl_q}) + $signed({2'b0, k_q}) - (CW+2)'(1);
		ksum16  = $signed({{(DW-CW-18){ksum[CW+1]}}, ksum, 16'b0});
		wdiff   = $signed({1'b0, w_q[0]}) - $signed({1'b0, w_q[2]});
		wdiff_abs = wdiff[16] ? 17'(-wdiff) : 17'(wdiff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= FRACTION_RESET;
			nthr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRACTION:  frac_q <= cfg_data;
				CFG_THRESHOLD: nthr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			bin_count_q    <= '0;
			peak_q         <= 16'sh8000;
			peak_idx_q     <= '0;
			trough_q       <= 16'sh7FFF;
			trough_idx_q   <= '0;
			last_err_q     <= '0;
			result_valid_q <= 1'b0;
			try_q          <= '0;
			dv_cnt_q       <= '0;
		end else begin
			// in S_FIN the output register is reloaded instead
			if (result_valid_q && result_ready && (state_q != S_FIN)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (wr_en) begin
							if (item.sample > peak_q) begin
								peak_q     <= item.sample;
								peak_idx_q <= bin_count_q[AW-1:0];
							end
							if (item.sample < trough_q) begin
								trough_q     <= item.sample;
								trough_idx_q <= bin_count_q[AW-1:0];
							end
							bin_count_q <= bin_count_q + CW'(1);
						end
						if (item.last_bin) begin
							mean_q  <= item.bg_mean;
							sigma_q <= item.baseline_sigma;
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					n_q   <= bin_count_q;
					ext_q <= dmag_c;
					pk_q  <= (abs_dmax > abs_dmin) ? peak_idx_q : trough_idx_q;
					bin_count_q  <= '0;
					peak_q       <= 16'sh8000;
					peak_idx_q   <= '0;
					trough_q     <= 16'sh7FFF;
					trough_idx_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					base_q  <= ext_q * $signed({1'b0, frac_q});
					thr_q   <= {32'(nthr_q) * 32'(sigma_q), 8'b0};
					try_q   <= '0;
					state_q <= S_LEV;
				end
				S_LEV: begin
					lev_q   <= lev_c;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (abs_lev < {2'b0, thr_q}) begin
						pend_q.width_turns <= '0;
						pend_q.width_error <= last_err_q[14:0];
						pend_q.below_noise <= 1'b1;
						state_q <= S_FIN;
					end else begin
						alev_q  <= abs_lev;
						idx_q   <= pk_q;
						k_q     <= '0;
						dir_q   <= 1'b0;
						state_q <= S_WRD;
					end
				end
				S_WRD, S_WCK: begin
					if (walk_stop) begin
						// left edge uses the stop bin and the next; right uses the one before
						if (!dir_q) begin
							kl_q     <= k_q;
							x2_idx_q <= idx_inc;
						end else begin
							x2_idx_q <= idx_q;
							idx_q    <= idx_dec;
						end
						state_q <= S_E1;
					end else if (state_q == S_WRD) begin
						state_q <= S_WCK;
					end else begin
						k_q     <= k_q + CW'(1);
						idx_q   <= dir_q ? idx_inc : idx_dec;
						state_q <= S_WRD;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					y1_q    <= amp_c;
					state_q <= S_E3;
				end
				S_E3: begin
					dv_rem_q <= '0;
					dv_den_q <= den_mag;
					dv_neg_q <= num_c[DW-1] ^ den_c[AMPW];
					if (den_c == '0) begin
						// flat edge: offset zero
						dv_quo_q <= '0;
						dv_cnt_q <= '0;
					end else begin
						dv_quo_q <= num_mag + DW'(den_mag >> 1);
						dv_cnt_q <= DCW'(DW);
					end
					state_q <= S_DVO;
				end
				S_DVO, S_DVW: begin
					if (dv_cnt_q != '0) begin
						if (!rem_sub[DVW]) begin
							dv_rem_q <= rem_sub;
							dv_quo_q <= {dv_quo_q[DW-2:0], 1'b1};
						end else begin
							dv_rem_q <= rem_sh;
							dv_quo_q <= {dv_quo_q[DW-2:0], 1'b0};
						end
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else if (state_q == S_DVO) begin
						if (!dir_q) begin
							offl_q  <= q_signed;
							idx_q   <= pk_q;
							k_q     <= '0;
							dir_q   <= 1'b1;
							state_q <= S_WRD;
						end else begin
							dist_q  <= q_signed - offl_q + ksum16;
							state_q <= S_WRAP;
						end
					end else begin
						if (q_signed < 0) begin
							w_q[try_q] <= '0;
						end else if (q_signed > DW'(65535)) begin
							w_q[try_q] <= 16'hFFFF;
						end else begin
							w_q[try_q] <= q_signed[15:0];
						end
						if (try_q == 2'd2) begin
							state_q <= S_ERR;
						end else begin
							try_q   <= try_q + 2'd1;
							state_q <= S_LEV;
						end
					end
				end
				S_WRAP: begin
					if (dist_q < 0) begin
						dist_q <= dist_q + $signed({{(DW-CW-16){1'b0}}, n_q, 16'b0});
					end
					state_q <= S_DIST;
				end
				S_DIST: begin
					dv_rem_q <= '0;
					dv_den_q <= den_mag;
					dv_neg_q <= num_c[DW-1];
					dv_quo_q <= num_mag + DW'(den_mag >> 1);
					dv_cnt_q <= DCW'(DW);
					state_q  <= S_DVW;
				end
				S_ERR: begin
					last_err_q <= wdiff_abs[16:1];
					pend_q.width_turns <= w_q[1];
					pend_q.width_error <= wdiff_abs[15:1];
					pend_q.below_noise <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!result_valid_q || result_ready) begin
						result_q       <= pend_q;
						result_valid_q <= 1'b1;
						state_q        <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/pwfp_checker.sv @@
// Port-level assertions for the pulse width block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pwfp_checker
	import pwfp_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      item_valid,
	input wire logic      item_ready,
	input wire in_item_t  item,
	input wire logic      result_valid,
	input wire logic      result_ready,
	input wire out_item_t result
);
	// a pending result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a profile under the noise floor reports zero width
	a_noise_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.below_noise |-> result.width_turns == 16'd0)
		else $error("below-noise result with nonzero width");

	// the end of a profile starts the computation, so loading pauses
	a_last_pause: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last_bin |=> !item_ready)
		else $error("item taken right after last bin");
endmodule

bind pulse_width_at_fraction_of_peak pwfp_checker u_pwfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire
